>>> rtl/bfnp_pkg.sv
// Package for the bitmap find next/prev block: field widths, request modes,
// controller state codes and parameter defaults. No dependencies.
`timescale 1ns / 1ps
package bfnp_pkg;

  localparam int unsigned MAX_BITS_DEF  = 4096;
  localparam int unsigned WORD_BITS_DEF = 64;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned IDX_W  = 14;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE     = 3'd0,
    MODE_READ      = 3'd1,
    MODE_NEXT_ONE  = 3'd2,
    MODE_NEXT_ZERO = 3'd3,
    MODE_PREV_ONE  = 3'd4,
    MODE_PREV_ZERO = 3'd5
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FIX  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

endpackage

>>> rtl/bfnp_req_if.sv
// Request channel: valid/ready plus mode, bit position and write value.
// Depends on bfnp_pkg.
`timescale 1ns / 1ps
interface bfnp_req_if
  import bfnp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  bit_position;
  logic              write_value;

  modport source (output valid, output mode, output bit_position, output write_value,
                  input ready);
  modport sink   (input valid, input mode, input bit_position, input write_value,
                  output ready);
endinterface

>>> rtl/bfnp_rsp_if.sv
// Response channel: valid/ready plus result index and bit value.
// Depends on bfnp_pkg.
`timescale 1ns / 1ps
interface bfnp_rsp_if
  import bfnp_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [IDX_W-1:0] result_index;
  logic                    bit_value;

  modport source (output valid, output result_index, output bit_value, input ready);
  modport sink   (input valid, input result_index, input bit_value, output ready);
endinterface

>>> rtl/bfnp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bfnp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/bfnp_word_search.sv
// Searches one word for the lowest or highest bit equal to a wanted value
// inside an inclusive offset window. Depends on bfnp_pkg.
`timescale 1ns / 1ps
module bfnp_word_search
  import bfnp_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0]         data_i,
  input  logic                         want_i,
  input  logic                         backward_i,
  input  logic [$clog2(WORD_BITS)-1:0] lo_i,
  input  logic [$clog2(WORD_BITS)-1:0] hi_i,
  output logic                         found_o,
  output logic [$clog2(WORD_BITS)-1:0] off_o
);

  localparam int unsigned OW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] match;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      match[j] = (data_i[j] == want_i) && (OW'(j) >= lo_i) && (OW'(j) <= hi_i);
    end
    found_o = |match;
    off_o   = '0;
    if (backward_i) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if (match[j]) off_o = OW'(j);
      end
    end else begin
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
        if (match[j]) off_o = OW'(j);
      end
    end
  end

endmodule

>>> rtl/bitmap_find_next_prev_top.sv
// Bitmap with single-bit write/read and next/prev set/clear search.
// Depends on bfnp_pkg, bfnp_req_if, bfnp_rsp_if, bfnp_ram, bfnp_word_search.
//
// Usage: a request word (mode, bit_position, write_value) enters on req_i;
// every request yields one response word on rsp_o. The bits live in one RAM
// of MAX_BITS/WORD_BITS words with registered read.
// Flow: write and read go IDLE, ACC, DONE to the output register; a search
// goes IDLE, then SCAN once per word scanned (up to MAX_BITS/WORD_BITS
// words, one per step as set by the single RAM read port), then DONE.
// Requests resolved without a RAM access go IDLE, DONE. One request is in
// work at a time; the next one is taken while the previous response waits.
// Config: cfg_we_i writes bits_in_use (saturated to MAX_BITS). Words fully
// past the new length are dropped at once; a partially covered word is
// trimmed by a read-modify-write before the next request is taken.
// Reset: all bits read as zero (per-word valid flags), bits_in_use is
// MAX_BITS. If the receiver stalls, the response holds and the controller
// waits with the following result.
`timescale 1ns / 1ps
module bitmap_find_next_prev_top
  import bfnp_pkg::*;
#(
  parameter int unsigned MAX_BITS  = MAX_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  bfnp_req_if.sink         req_i,
  bfnp_rsp_if.source       rsp_o
);

  localparam int unsigned WORDS = MAX_BITS / WORD_BITS;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam int unsigned OW    = $clog2(WORD_BITS);
  localparam int unsigned PW    = AW + OW;
  localparam int unsigned LW    = PW + 1;

  state_e                  state_q, state_d;
  logic [LW-1:0]           len_q;
  logic [WORDS-1:0]        valid_q;
  logic                    fix_pend_q;
  logic [AW-1:0]           fix_word_q;
  logic [OW-1:0]           fix_off_q;
  logic [MODE_W-1:0]       mode_q, mode_d;
  logic                    wv_q, wv_d;
  logic [AW-1:0]           cur_q, cur_d;
  logic [OW-1:0]           off_q, off_d;
  logic                    first_q, first_d;
  logic signed [IDX_W-1:0] res_q, res_d;
  logic                    bit_q, bit_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [IDX_W-1:0] out_idx_q;
  logic                    out_bit_q;
  logic                    out_load;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]    ram_wdata, ram_rdata, word_eff;

  logic [LW+LEN_W-1:0]     cfg_wide;
  logic [LW-1:0]           cfg_len;
  logic [PW+POS_W-1:0]     pos_wide;
  logic [PW-1:0]           pos_w;
  logic [LW-1:0]           last_pos;
  logic [PW-1:0]           back_start;
  logic [IDX_W+LW-1:0]     len_wide;
  logic [IDX_W+PW-1:0]     hit_wide;

  logic                    fwd, want, s_found;
  logic [OW-1:0]           s_lo, s_hi, s_off;

  assign cfg_wide = {{LW{1'b0}}, cfg_wdata_i};
  assign cfg_len  = (cfg_wide > (LW + LEN_W)'(MAX_BITS)) ? LW'(MAX_BITS) : cfg_wide[LW-1:0];
  assign pos_wide = {{PW{1'b0}}, req_i.bit_position};
  assign pos_w    = pos_wide[PW-1:0];
  assign last_pos = len_q - LW'(1);
  assign back_start = ({1'b0, pos_w} > last_pos) ? last_pos[PW-1:0] : pos_w;
  assign len_wide = {{IDX_W{1'b0}}, len_q};
  assign hit_wide = {{IDX_W{1'b0}}, cur_q, s_off};
  assign word_eff = valid_q[cur_q] ? ram_rdata : '0;

  assign fwd  = (mode_q == MODE_NEXT_ONE) || (mode_q == MODE_NEXT_ZERO);
  assign want = (mode_q == MODE_NEXT_ONE) || (mode_q == MODE_PREV_ONE);

  always_comb begin
    if (fwd) begin
      s_lo = first_q ? off_q : '0;
      s_hi = (cur_q == last_pos[PW-1:OW]) ? last_pos[OW-1:0] : OW'(WORD_BITS - 1);
    end else begin
      s_lo = '0;
      s_hi = first_q ? off_q : OW'(WORD_BITS - 1);
    end
  end

  bfnp_word_search #(.WORD_BITS(WORD_BITS)) u_search (
    .data_i     (word_eff),
    .want_i     (want),
    .backward_i (!fwd),
    .lo_i       (s_lo),
    .hi_i       (s_hi),
    .found_o    (s_found),
    .off_o      (s_off)
  );

  bfnp_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready        = (state_q == ST_IDLE) && !fix_pend_q;
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_index = out_idx_q;
  assign rsp_o.bit_value    = out_bit_q;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    wv_d        = wv_q;
    cur_d       = cur_q;
    off_d       = off_q;
    first_d     = first_q;
    res_d       = res_q;
    bit_d       = bit_q;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cur_q;
    ram_wdata   = word_eff;
    ram_raddr   = cur_q;
    out_valid_d = out_valid_q && !rsp_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (fix_pend_q) begin
          ram_raddr = fix_word_q;
          cur_d     = fix_word_q;
          state_d   = ST_FIX;
        end else if (req_i.valid) begin
          mode_d  = req_i.mode;
          wv_d    = req_i.write_value;
          res_d   = '0;
          bit_d   = 1'b0;
          first_d = 1'b1;
          ram_raddr = pos_w[PW-1:OW];
          cur_d     = pos_w[PW-1:OW];
          off_d     = pos_w[OW-1:0];
          state_d   = ST_DONE;
          case (req_i.mode)
            MODE_WRITE, MODE_READ: begin
              if ({1'b0, pos_w} < len_q) state_d = ST_ACC;
            end
            MODE_NEXT_ONE, MODE_NEXT_ZERO: begin
              if ({1'b0, pos_w} < len_q) state_d = ST_SCAN;
              else res_d = len_wide[IDX_W-1:0];
            end
            MODE_PREV_ONE, MODE_PREV_ZERO: begin
              if (len_q == '0) begin
                res_d = '1;
              end else begin
                ram_raddr = back_start[PW-1:OW];
                cur_d     = back_start[PW-1:OW];
                off_d     = back_start[OW-1:0];
                state_d   = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIX: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        for (int j = 0; j < WORD_BITS; j++) begin
          ram_wdata[j] = word_eff[j] && (OW'(j) < fix_off_q);
        end
        state_d = ST_IDLE;
      end
      ST_ACC: begin
        if (mode_q == MODE_WRITE) begin
          ram_we           = 1'b1;
          ram_wdata        = word_eff;
          ram_wdata[off_q] = wv_q;
        end else begin
          bit_d = word_eff[off_q];
        end
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        first_d = 1'b0;
        if (s_found) begin
          res_d   = hit_wide[IDX_W-1:0];
          state_d = ST_DONE;
        end else if (fwd && (cur_q == last_pos[PW-1:OW])) begin
          res_d   = len_wide[IDX_W-1:0];
          state_d = ST_DONE;
        end else if (!fwd && (cur_q == '0)) begin
          res_d   = '1;
          state_d = ST_DONE;
        end else begin
          cur_d     = fwd ? cur_q + AW'(1) : cur_q - AW'(1);
          ram_raddr = cur_d;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LW'(MAX_BITS);
      valid_q     <= '0;
      fix_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (ram_we) valid_q[ram_waddr] <= 1'b1;
      if (state_q == ST_FIX) fix_pend_q <= 1'b0;
      if (cfg_we_i) begin
        len_q <= cfg_len;
        for (int i = 0; i < WORDS; i++) begin
          if ((LW'(i) << OW) >= cfg_len) valid_q[i] <= 1'b0;
        end
        fix_pend_q <= (cfg_len[OW-1:0] != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    wv_q    <= wv_d;
    cur_q   <= cur_d;
    off_q   <= off_d;
    first_q <= first_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
    if (cfg_we_i) begin
      fix_word_q <= cfg_len[PW-1:OW];
      fix_off_q  <= cfg_len[OW-1:0];
    end
    if (out_load) begin
      out_idx_q <= res_q;
      out_bit_q <= bit_q;
    end
  end

endmodule
